FILE: rtl/core/absum_pkg.sv
`default_nettype none

package absum_pkg;

  localparam int SLOT_BYTES = 4096;
  localparam int SLOT_AW    = $clog2(SLOT_BYTES);
  localparam int LEN_W      = SLOT_AW + 1;
  localparam int MEM_AW     = SLOT_AW + 1;
  localparam int MEM_DEPTH  = 2 * SLOT_BYTES;

  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [7:0]  HEAD_BYTE  = 8'hFF;
  localparam logic [LEN_W-1:0] HEAD_MIN_LEN = LEN_W'(4);
  localparam logic [7:0]  FAULT_LIMIT = 8'd2;
  localparam logic [7:0]  FAULT_MAX   = 8'hFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  localparam logic REG_PAYLOAD_LENGTH    = 1'b0;
  localparam logic REG_EXPECTED_CHECKSUM = 1'b1;

  localparam int IN_BITS    = 3 + SLOT_AW + 8;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_VALIDATE = 3'd2,
    CMD_PROMOTE  = 3'd3,
    CMD_ROLLBACK = 3'd4,
    CMD_FAULT    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_STATE      = 3'd1,
    STS_RANGE      = 3'd2,
    STS_CRC        = 3'd3,
    STS_HEADER     = 3'd4,
    STS_NO_BACKUP  = 3'd5,
    STS_INCOMPLETE = 3'd6
  } sts_e;

  typedef enum logic [2:0] {
    SLOT_EMPTY     = 3'd0,
    SLOT_STAGING   = 3'd1,
    SLOT_VALIDATED = 3'd2,
    SLOT_ACTIVE    = 3'd3,
    SLOT_ROLLED    = 3'd4
  } slot_e;

  // Packed so that accepted lands in bit 0.
  typedef struct packed {
    logic [7:0] fault_tally;
    slot_e      slot_b_status;
    slot_e      slot_a_status;
    logic       backup_index;
    logic       active_index;
    sts_e       status_code;
    logic       accepted;
  } res_t;

  localparam int RES_W       = $bits(res_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic               wr;
    logic               clr;
    logic               crc;
    logic               slot;
    logic [SLOT_AW-1:0] offset;
    logic [7:0]         data;
    logic [LEN_W-1:0]   len;
  } eng_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] crc;
    logic        head_ff;
  } eng_rsp_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ab_slot_update_manager.sv
// Channel   Direction  Transaction carries
// s_axis    in         command, byte_offset, data_byte
// m_axis    out        accepted, status_code, active/backup index, slot states, fault_tally
// cfg       in         write of payload_length (index 0) or expected_checksum (index 1)
//
// Write, promote, rollback, fault and refused commands are done in S_IDLE; the result goes
// to the output register, or waits in S_HOLD while m_axis is full. Start clears
// payload_length bytes, one per cycle. Validate walks the staged image through the CRC,
// one byte per cycle.
// Both walks run on the image memory in the engine; no item is taken meanwhile.
// Reset needs no clearing pass: a slot is only read or written after start cleared it.
// One finished result can wait on m_axis while the next command is taken.
`default_nettype none

module ab_slot_update_manager
  import absum_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // command [2:0], byte_offset [14:3], data_byte [22:15], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // accepted [0], status_code [3:1], active_index [4], backup_index [5],
  // slot_a_status [8:6], slot_b_status [11:9], fault_tally [19:12], zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [31:0]            cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_CRC   = 4'b0100,
    S_HOLD  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic             act_q, act_d;
  logic             bak_q, bak_d;
  slot_e            sa_q, sa_d;
  slot_e            sb_q, sb_d;
  logic [LEN_W-1:0] slen_q, slen_d;
  logic [31:0]      scrc_q, scrc_d;
  logic [15:0]      rcv_q, rcv_d;
  logic [7:0]       flt_q, flt_d;
  logic [LEN_W-1:0] cfg_len_q;
  logic [31:0]      cfg_crc_q;
  res_t             res_q, res_d;
  res_t             out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic               [2:0] cmd;
  logic [SLOT_AW-1:0] offset;
  logic [7:0]         data;
  logic               stg;
  slot_e              stg_stat;
  logic               out_free;
  logic               rb_ok;
  logic [7:0]         flt_inc;
  logic               acc;
  sts_e               code;
  logic               go_clr, go_crc;
  res_t               res_now;
  eng_req_t           eng_req;
  eng_rsp_t           eng_rsp;

  assign cmd      = s_axis_tdata[2:0];
  assign offset   = s_axis_tdata[3 +: SLOT_AW];
  assign data     = s_axis_tdata[3 + SLOT_AW +: 8];
  assign stg      = ~act_q;
  assign stg_stat = stg ? sb_q : sa_q;
  assign out_free = !out_vld_q || m_axis_tready;
  assign rb_ok    = (act_q != bak_q);
  assign flt_inc  = (flt_q == FAULT_MAX) ? flt_q : flt_q + 8'd1;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    bak_d     = bak_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    slen_d    = slen_q;
    scrc_d    = scrc_q;
    rcv_d     = rcv_q;
    flt_d     = flt_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    acc       = 1'b1;
    code      = STS_OK;
    go_clr    = 1'b0;
    go_crc    = 1'b0;
    eng_req   = '0;
    eng_req.slot   = stg;
    eng_req.offset = offset;
    eng_req.data   = data;
    eng_req.len    = slen_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (cmd)
            CMD_START: begin
              if (cfg_len_q > LEN_W'(SLOT_BYTES)) begin
                acc  = 1'b0;
                code = STS_RANGE;
              end else begin
                slen_d = cfg_len_q;
                scrc_d = cfg_crc_q;
                rcv_d  = '0;
                if (stg) sb_d = SLOT_STAGING;
                else     sa_d = SLOT_STAGING;
                go_clr      = 1'b1;
                eng_req.clr = 1'b1;
                eng_req.len = cfg_len_q;
              end
            end
            CMD_WRITE: begin
              if (stg_stat != SLOT_STAGING) begin
                acc  = 1'b0;
                code = STS_STATE;
              end else if ({1'b0, offset} >= slen_q) begin
                acc  = 1'b0;
                code = STS_RANGE;
              end else begin
                eng_req.wr = 1'b1;
                if (rcv_q != COUNT_MAX) begin
                  rcv_d = rcv_q + 16'd1;
                end
              end
            end
            CMD_VALIDATE: begin
              if (stg_stat != SLOT_STAGING) begin
                acc  = 1'b0;
                code = STS_STATE;
              end else if (rcv_q != 16'(slen_q)) begin
                acc  = 1'b0;
                code = STS_INCOMPLETE;
              end else begin
                go_crc      = 1'b1;
                eng_req.crc = 1'b1;
              end
            end
            CMD_PROMOTE: begin
              if (stg_stat != SLOT_VALIDATED) begin
                acc  = 1'b0;
                code = STS_STATE;
              end else begin
                bak_d = act_q;
                act_d = stg;
                if (stg) sb_d = SLOT_ACTIVE;
                else     sa_d = SLOT_ACTIVE;
                flt_d = '0;
              end
            end
            CMD_ROLLBACK: begin
              if (!rb_ok) begin
                acc  = 1'b0;
                code = STS_NO_BACKUP;
              end else begin
                sa_d  = act_q ? SLOT_ACTIVE : SLOT_ROLLED;
                sb_d  = act_q ? SLOT_ROLLED : SLOT_ACTIVE;
                act_d = bak_q;
                flt_d = '0;
              end
            end
            CMD_FAULT: begin
              flt_d = flt_inc;
              if ((flt_inc >= FAULT_LIMIT) && rb_ok) begin
                sa_d  = act_q ? SLOT_ACTIVE : SLOT_ROLLED;
                sb_d  = act_q ? SLOT_ROLLED : SLOT_ACTIVE;
                act_d = bak_q;
                flt_d = '0;
              end
            end
            default: begin
              acc  = 1'b0;
              code = STS_STATE;
            end
          endcase

          res_now.accepted      = acc;
          res_now.status_code   = code;
          res_now.active_index  = act_d;
          res_now.backup_index  = bak_d;
          res_now.slot_a_status = sa_d;
          res_now.slot_b_status = sb_d;
          res_now.fault_tally   = flt_d;

          if (go_clr) begin
            res_d   = res_now;
            state_d = S_CLEAR;
          end else if (go_crc) begin
            state_d = S_CRC;
          end else if (out_free) begin
            out_d     = res_now;
            out_vld_d = 1'b1;
          end else begin
            res_d   = res_now;
            state_d = S_HOLD;
          end
        end else begin
          res_now = res_q;
        end
      end
      S_CLEAR: begin
        res_now = res_q;
        if (eng_rsp.done) begin
          state_d = S_HOLD;
        end
      end
      S_CRC: begin
        res_now = res_q;
        if (eng_rsp.done) begin
          if (eng_rsp.crc != scrc_q) begin
            acc  = 1'b0;
            code = STS_CRC;
            if (stg) sb_d = SLOT_EMPTY;
            else     sa_d = SLOT_EMPTY;
          end else if ((slen_q > HEAD_MIN_LEN) && eng_rsp.head_ff) begin
            acc  = 1'b0;
            code = STS_HEADER;
            if (stg) sb_d = SLOT_EMPTY;
            else     sa_d = SLOT_EMPTY;
          end else begin
            if (stg) sb_d = SLOT_VALIDATED;
            else     sa_d = SLOT_VALIDATED;
          end
          res_d.accepted      = acc;
          res_d.status_code   = code;
          res_d.active_index  = act_q;
          res_d.backup_index  = bak_q;
          res_d.slot_a_status = sa_d;
          res_d.slot_b_status = sb_d;
          res_d.fault_tally   = flt_q;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        res_now = res_q;
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        res_now = res_q;
        state_d = S_IDLE;
      end
    endcase
  end

  absum_image_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .rsp_o  (eng_rsp)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_q};

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= 1'b0;
      bak_q     <= 1'b0;
      sa_q      <= SLOT_ACTIVE;
      sb_q      <= SLOT_EMPTY;
      slen_q    <= '0;
      scrc_q    <= '0;
      rcv_q     <= '0;
      flt_q     <= '0;
      out_vld_q <= 1'b0;
      cfg_len_q <= '0;
      cfg_crc_q <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      bak_q     <= bak_d;
      sa_q      <= sa_d;
      sb_q      <= sb_d;
      slen_q    <= slen_d;
      scrc_q    <= scrc_d;
      rcv_q     <= rcv_d;
      flt_q     <= flt_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_EXPECTED_CHECKSUM) cfg_crc_q <= cfg_wdata_i;
        else                                    cfg_len_q <= cfg_wdata_i[LEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/absum_image_engine.sv
`default_nettype none

module absum_image_engine
  import absum_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire eng_req_t req_i,
  output eng_rsp_t      rsp_o
);

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_CLEAR = 3'b010,
    E_READ  = 3'b100
  } eng_state_e;

  eng_state_e       state_q, state_d;
  logic             slot_q, slot_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [31:0]      crc_q, crc_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_at0_q, rd_at1_q;
  logic [7:0]       b0_q, b1_q;

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rdata_q;
  logic             mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic             at_end;
  logic             done;

  assign at_end = (idx_q == len_q);

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    len_d     = len_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    rd_vld_d  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {slot_q, idx_q[SLOT_AW-1:0]};
    mem_wdata = 8'd0;
    mem_raddr = {slot_q, idx_q[SLOT_AW-1:0]};
    done      = 1'b0;
    if (rd_vld_q) begin
      crc_d = crc_byte(crc_q, rdata_q);
    end
    unique case (state_q)
      E_IDLE: begin
        if (req_i.wr) begin
          mem_we    = 1'b1;
          mem_waddr = {req_i.slot, req_i.offset};
          mem_wdata = req_i.data;
        end
        if (req_i.clr || req_i.crc) begin
          slot_d  = req_i.slot;
          len_d   = req_i.len;
          idx_d   = '0;
          crc_d   = CRC_INIT;
          state_d = req_i.clr ? E_CLEAR : E_READ;
        end
      end
      E_CLEAR: begin
        if (at_end) begin
          done    = 1'b1;
          state_d = E_IDLE;
        end else begin
          mem_we = 1'b1;
          idx_d  = idx_q + LEN_W'(1);
        end
      end
      E_READ: begin
        if (!at_end) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + LEN_W'(1);
        end else if (!rd_vld_q) begin
          done    = 1'b1;
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  assign rsp_o = '{done: done,
                   crc: crc_q ^ CRC_XOROUT,
                   head_ff: (b0_q == HEAD_BYTE) && (b1_q == HEAD_BYTE)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    crc_q  <= crc_d;
    if (mem_re) begin
      rd_at0_q <= (idx_q == LEN_W'(0));
      rd_at1_q <= (idx_q == LEN_W'(1));
    end
    if (rd_vld_q && rd_at0_q) begin
      b0_q <= rdata_q;
    end
    if (rd_vld_q && rd_at1_q) begin
      b1_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= E_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/absum_checker.sv
`default_nettype none

module absum_checker
  import absum_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  res_t res;
  assign res = res_t'(m_axis_tdata[RES_W-1:0]);

  // A result that is not taken stays on the bus unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // A command succeeds exactly when its status is ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.accepted == (res.status_code == STS_OK)))
    else $error("accepted flag disagrees with status");

  // The active slot is always marked active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.active_index ? (res.slot_b_status == SLOT_ACTIVE)
                                        : (res.slot_a_status == SLOT_ACTIVE)))
    else $error("active slot not in active state");

  // With a backup present, a second fault would already have rolled back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.active_index != res.backup_index) |-> res.fault_tally < FAULT_LIMIT)
    else $error("fault tally reached the limit while a backup exists");

endmodule

bind ab_slot_update_manager absum_checker u_absum_checker (.*);

`default_nettype wire
